// ===== hdl/apdtm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package apdtm_pkg;

  // Field widths.
  localparam int ANGLE_W = 22;
  localparam int RATE_W  = 17;
  localparam int TVEL_W  = 21;
  localparam int GAIN_W  = 16;
  localparam int DRIVE_W = 17;

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Internal widths.
  localparam int ERR_W = 24;              // wrapped angle error
  localparam int PP_W  = GAIN_W + ERR_W;  // full proportional product
  localparam int DP_W  = GAIN_W + RATE_W; // full derivative product
  localparam int P_SHIFT    = 12;
  localparam int D_SHIFT    = 4;
  localparam int RATE_SHIFT = 7;
  localparam int PT_W  = PP_W - P_SHIFT;
  localparam int DT_W  = DP_W - D_SHIFT;
  localparam int RS_W  = RATE_W - RATE_SHIFT;
  localparam int BS_W  = TVEL_W + 1;
  localparam int BRK_W = 28;
  localparam int MIX_W = 31;

  localparam int HALF_TURN    = 1048576;
  localparam int BRAKE_GAIN   = 20;
  localparam int REVERSE_GAIN = 5;
  localparam logic [GAIN_W-1:0] MAX_DRIVE_RESET = GAIN_W'(3800);

  localparam logic signed [ERR_W-1:0] HALF_LIM = ERR_W'(HALF_TURN);
  localparam logic signed [ERR_W-1:0] FULL_TURN = ERR_W'(2 * HALF_TURN);

  // Register indexes.
  localparam logic [2:0] REG_ROLL_P  = 3'd0;
  localparam logic [2:0] REG_ROLL_D  = 3'd1;
  localparam logic [2:0] REG_PITCH_P = 3'd2;
  localparam logic [2:0] REG_PITCH_D = 3'd3;
  localparam logic [2:0] REG_YAW_P   = 3'd4;
  localparam logic [2:0] REG_YAW_D   = 3'd5;
  localparam logic [2:0] REG_MAX     = 3'd6;

  typedef struct packed {
    logic signed [GAIN_W-1:0] roll_p_gain;
    logic signed [GAIN_W-1:0] roll_d_gain;
    logic signed [GAIN_W-1:0] pitch_p_gain;
    logic signed [GAIN_W-1:0] pitch_d_gain;
    logic signed [GAIN_W-1:0] yaw_p_gain;
    logic signed [GAIN_W-1:0] yaw_d_gain;
    logic        [GAIN_W-1:0] max_drive;
  } gains_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic signed [ANGLE_W-1:0] roll_setpoint;
    logic signed [ANGLE_W-1:0] pitch_setpoint;
    logic signed [ANGLE_W-1:0] yaw_setpoint;
    logic signed [RATE_W-1:0]  roll_rate;
    logic signed [RATE_W-1:0]  pitch_rate;
    logic signed [RATE_W-1:0]  yaw_rate;
    logic signed [TVEL_W-1:0]  tail_velocity;
    logic                      airborne;
    logic                      enabled;
  } sample_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  roll_err;
    logic signed [ERR_W-1:0]  pitch_err;
    logic signed [ERR_W-1:0]  yaw_err;
    logic signed [RATE_W-1:0] roll_rate;
    logic signed [RATE_W-1:0] pitch_rate;
    logic signed [RATE_W-1:0] yaw_rate;
    logic signed [TVEL_W-1:0] tail_velocity;
    logic                     airborne;
    logic                     enabled;
  } err_stage_t;

  typedef struct packed {
    logic signed [PT_W-1:0]  roll_p;
    logic signed [DT_W-1:0]  roll_d;
    logic signed [PT_W-1:0]  pitch_p;
    logic signed [DT_W-1:0]  pitch_d;
    logic signed [PT_W-1:0]  yaw_p;
    logic signed [DT_W-1:0]  yaw_d;
    logic signed [BRK_W-1:0] brake;
    logic                    airborne;
    logic                    enabled;
  } prod_stage_t;

  // Angle error wrapped once by a full turn when it lies beyond plus or minus a half turn.
  function automatic logic signed [ERR_W-1:0] wrap_err(
    input logic signed [ANGLE_W-1:0] a,
    input logic signed [ANGLE_W-1:0] s
  );
    logic signed [ERR_W-1:0] e;
    e = ERR_W'(a) - ERR_W'(s);
    if (e > HALF_LIM) begin
      e = e - FULL_TURN;
    end else if (e < -HALF_LIM) begin
      e = e + FULL_TURN;
    end
    return e;
  endfunction

  function automatic logic signed [PT_W-1:0] p_term(
    input logic signed [GAIN_W-1:0] kp,
    input logic signed [ERR_W-1:0]  err
  );
    logic signed [PP_W-1:0] prod;
    prod = kp * err;
    return PT_W'(prod >>> P_SHIFT);
  endfunction

  function automatic logic signed [DT_W-1:0] d_term(
    input logic signed [GAIN_W-1:0] kd,
    input logic signed [RATE_W-1:0] rate
  );
    logic signed [DP_W-1:0] prod;
    prod = kd * rate;
    return DT_W'(prod >>> D_SHIFT);
  endfunction

  // Ground brake law for the tail: -20 * (tail_velocity + 5 * (pitch_rate >> 7)).
  function automatic logic signed [BRK_W-1:0] brake_term(
    input logic signed [RATE_W-1:0] pr,
    input logic signed [TVEL_W-1:0] tv
  );
    logic signed [RS_W-1:0]  rs;
    logic signed [BS_W-1:0]  s;
    logic signed [BRK_W-1:0] b;
    rs = RS_W'(pr >>> RATE_SHIFT);
    s  = BS_W'(tv) + BS_W'(rs) * BS_W'(REVERSE_GAIN);
    b  = BRK_W'(s) * BRK_W'(-BRAKE_GAIN);
    return b;
  endfunction

  function automatic logic signed [DRIVE_W-1:0] saturate(
    input logic signed [MIX_W-1:0] v,
    input logic        [GAIN_W-1:0] lim
  );
    logic signed [MIX_W-1:0] hi;
    hi = MIX_W'($signed({1'b0, lim}));
    if (v > hi) begin
      return DRIVE_W'(hi);
    end else if (v < -hi) begin
      return DRIVE_W'(-hi);
    end
    return DRIVE_W'(v);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/apdtm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface apdtm_in_if;
  import apdtm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] roll_angle;
  logic signed [ANGLE_W-1:0] pitch_angle;
  logic signed [ANGLE_W-1:0] yaw_angle;
  logic signed [ANGLE_W-1:0] roll_setpoint;
  logic signed [ANGLE_W-1:0] pitch_setpoint;
  logic signed [ANGLE_W-1:0] yaw_setpoint;
  logic signed [RATE_W-1:0]  roll_rate;
  logic signed [RATE_W-1:0]  pitch_rate;
  logic signed [RATE_W-1:0]  yaw_rate;
  logic signed [TVEL_W-1:0]  tail_velocity;
  logic                      airborne;
  logic                      enabled;

  modport source (
    output valid, roll_angle, pitch_angle, yaw_angle, roll_setpoint, pitch_setpoint,
           yaw_setpoint, roll_rate, pitch_rate, yaw_rate, tail_velocity, airborne, enabled,
    input  ready
  );

  modport sink (
    input  valid, roll_angle, pitch_angle, yaw_angle, roll_setpoint, pitch_setpoint,
           yaw_setpoint, roll_rate, pitch_rate, yaw_rate, tail_velocity, airborne, enabled,
    output ready
  );
endinterface

interface apdtm_out_if;
  import apdtm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] fore_drive;
  logic signed [DRIVE_W-1:0] aft_drive;
  logic signed [DRIVE_W-1:0] tail_drive;

  modport source (
    output valid, fore_drive, aft_drive, tail_drive,
    input  ready
  );

  modport sink (
    input  valid, fore_drive, aft_drive, tail_drive,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/apdtm_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module apdtm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [apdtm_pkg::ADDR_W-1:0]   paddr,
  input  logic [apdtm_pkg::DATA_W-1:0]   pwdata,
  output logic [apdtm_pkg::DATA_W-1:0]   prdata,
  output logic                           pready,
  output apdtm_pkg::gains_t              gains
);
  import apdtm_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.roll_p_gain  <= '0;
      gains.roll_d_gain  <= '0;
      gains.pitch_p_gain <= '0;
      gains.pitch_d_gain <= '0;
      gains.yaw_p_gain   <= '0;
      gains.yaw_d_gain   <= '0;
      gains.max_drive    <= MAX_DRIVE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ROLL_P:  gains.roll_p_gain  <= pwdata[GAIN_W-1:0];
        REG_ROLL_D:  gains.roll_d_gain  <= pwdata[GAIN_W-1:0];
        REG_PITCH_P: gains.pitch_p_gain <= pwdata[GAIN_W-1:0];
        REG_PITCH_D: gains.pitch_d_gain <= pwdata[GAIN_W-1:0];
        REG_YAW_P:   gains.yaw_p_gain   <= pwdata[GAIN_W-1:0];
        REG_YAW_D:   gains.yaw_d_gain   <= pwdata[GAIN_W-1:0];
        REG_MAX:     gains.max_drive    <= pwdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Gains read back sign-extended, the limit zero-extended.
  always_comb begin
    unique case (reg_idx)
      REG_ROLL_P:  prdata = DATA_W'(gains.roll_p_gain);
      REG_ROLL_D:  prdata = DATA_W'(gains.roll_d_gain);
      REG_PITCH_P: prdata = DATA_W'(gains.pitch_p_gain);
      REG_PITCH_D: prdata = DATA_W'(gains.pitch_d_gain);
      REG_YAW_P:   prdata = DATA_W'(gains.yaw_p_gain);
      REG_YAW_D:   prdata = DATA_W'(gains.yaw_d_gain);
      REG_MAX:     prdata = DATA_W'(gains.max_drive);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/apdtm_err.sv =====
`timescale 1ns / 1ps
`default_nettype none

module apdtm_err (
  input  logic                   clk,
  input  logic                   en,
  input  apdtm_pkg::sample_t     smp,
  output apdtm_pkg::err_stage_t  es
);
  import apdtm_pkg::*;

  err_stage_t es_next;

  always_comb begin
    es_next.roll_err      = wrap_err(smp.roll_angle, smp.roll_setpoint);
    es_next.pitch_err     = wrap_err(smp.pitch_angle, smp.pitch_setpoint);
    es_next.yaw_err       = wrap_err(smp.yaw_angle, smp.yaw_setpoint);
    es_next.roll_rate     = smp.roll_rate;
    es_next.pitch_rate    = smp.pitch_rate;
    es_next.yaw_rate      = smp.yaw_rate;
    es_next.tail_velocity = smp.tail_velocity;
    es_next.airborne      = smp.airborne;
    es_next.enabled       = smp.enabled;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      es <= es_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/apdtm_prod.sv =====
`timescale 1ns / 1ps
`default_nettype none

module apdtm_prod (
  input  logic                   clk,
  input  logic                   en,
  input  apdtm_pkg::gains_t      gains,
  input  apdtm_pkg::err_stage_t  es,
  output apdtm_pkg::prod_stage_t ps
);
  import apdtm_pkg::*;

  prod_stage_t ps_next;

  // Six independent 16-bit gain multipliers, each already scaled by its shift, and the ground brake term.
  always_comb begin
    ps_next.roll_p   = p_term(gains.roll_p_gain, es.roll_err);
    ps_next.roll_d   = d_term(gains.roll_d_gain, es.roll_rate);
    ps_next.pitch_p  = p_term(gains.pitch_p_gain, es.pitch_err);
    ps_next.pitch_d  = d_term(gains.pitch_d_gain, es.pitch_rate);
    ps_next.yaw_p    = p_term(gains.yaw_p_gain, es.yaw_err);
    ps_next.yaw_d    = d_term(gains.yaw_d_gain, es.yaw_rate);
    ps_next.brake    = brake_term(es.pitch_rate, es.tail_velocity);
    ps_next.airborne = es.airborne;
    ps_next.enabled  = es.enabled;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps <= ps_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/apdtm_mix.sv =====
`timescale 1ns / 1ps
`default_nettype none

module apdtm_mix (
  input  logic                                clk,
  input  logic                                en,
  input  logic [apdtm_pkg::GAIN_W-1:0]        max_drive,
  input  apdtm_pkg::prod_stage_t              ps,
  output logic signed [apdtm_pkg::DRIVE_W-1:0] fore_drive,
  output logic signed [apdtm_pkg::DRIVE_W-1:0] aft_drive,
  output logic signed [apdtm_pkg::DRIVE_W-1:0] tail_drive
);
  import apdtm_pkg::*;

  logic signed [MIX_W-1:0]   roll_pd;
  logic signed [MIX_W-1:0]   pitch_pd;
  logic signed [MIX_W-1:0]   yaw_pd;
  logic signed [MIX_W-1:0]   tail_raw;
  logic signed [DRIVE_W-1:0] fore_next;
  logic signed [DRIVE_W-1:0] aft_next;
  logic signed [DRIVE_W-1:0] tail_next;

  always_comb begin
    roll_pd  = MIX_W'(ps.roll_p) + MIX_W'(ps.roll_d);
    pitch_pd = MIX_W'(ps.pitch_p) + MIX_W'(ps.pitch_d);
    yaw_pd   = MIX_W'(ps.yaw_p) + MIX_W'(ps.yaw_d);
    tail_raw = ps.airborne ? pitch_pd : MIX_W'(ps.brake);
    if (ps.enabled) begin
      fore_next = saturate(roll_pd - yaw_pd, max_drive);
      aft_next  = saturate(roll_pd + yaw_pd, max_drive);
      tail_next = saturate(tail_raw, max_drive);
    end else begin
      fore_next = '0;
      aft_next  = '0;
      tail_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fore_drive <= fore_next;
      aft_drive  <= aft_next;
      tail_drive <= tail_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/attitude_pd_thrust_mixer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Attitude PD controller with thruster mixing. Every sample transaction yields
// exactly one result transaction with the fore, aft and tail drives. The block
// is a three-stage pipeline (error wrap, six 16-bit gain multipliers, PD sum with
// mixing and saturation) that accepts one transaction per clock while not stalled; a
// sample is registered by the error, product and mix stages in turn before its result
// is presented. All stages advance together, so the only stall is result.ready held
// low while a result is waiting, and then sample.ready drops in the same cycle. Gains
// and the drive limit are written through the APB port at byte address 4*i and should
// only change while the pipeline is empty.
module attitude_pd_thrust_mixer_top (
  input  logic                         clk,
  input  logic                         rst,
  apdtm_in_if.sink                     sample,
  apdtm_out_if.source                  result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [apdtm_pkg::ADDR_W-1:0] paddr,
  input  logic [apdtm_pkg::DATA_W-1:0] pwdata,
  output logic [apdtm_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);
  import apdtm_pkg::*;

  logic        advance;
  logic        v1;
  logic        v2;
  logic        v3;
  gains_t      gains;
  sample_t     smp;
  err_stage_t  es;
  prod_stage_t ps;

  assign advance      = !v3 || result.ready;
  assign sample.ready = advance;
  assign result.valid = v3;

  always_comb begin
    smp.roll_angle     = sample.roll_angle;
    smp.pitch_angle    = sample.pitch_angle;
    smp.yaw_angle      = sample.yaw_angle;
    smp.roll_setpoint  = sample.roll_setpoint;
    smp.pitch_setpoint = sample.pitch_setpoint;
    smp.yaw_setpoint   = sample.yaw_setpoint;
    smp.roll_rate      = sample.roll_rate;
    smp.pitch_rate     = sample.pitch_rate;
    smp.yaw_rate       = sample.yaw_rate;
    smp.tail_velocity  = sample.tail_velocity;
    smp.airborne       = sample.airborne;
    smp.enabled        = sample.enabled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= sample.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  apdtm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains   (gains)
  );

  apdtm_err u_err (
    .clk (clk),
    .en  (advance),
    .smp (smp),
    .es  (es)
  );

  apdtm_prod u_prod (
    .clk   (clk),
    .en    (advance),
    .gains (gains),
    .es    (es),
    .ps    (ps)
  );

  apdtm_mix u_mix (
    .clk        (clk),
    .en         (advance),
    .max_drive  (gains.max_drive),
    .ps         (ps),
    .fore_drive (result.fore_drive),
    .aft_drive  (result.aft_drive),
    .tail_drive (result.tail_drive)
  );

  // Every delivered drive lies inside the configured limit.
  assert property (@(posedge clk) disable iff (rst)
    result.valid |->
      ($signed(result.fore_drive) <= $signed({1'b0, gains.max_drive}) &&
       $signed(result.fore_drive) >= -$signed({1'b0, gains.max_drive}) &&
       $signed(result.aft_drive)  <= $signed({1'b0, gains.max_drive}) &&
       $signed(result.aft_drive)  >= -$signed({1'b0, gains.max_drive}) &&
       $signed(result.tail_drive) <= $signed({1'b0, gains.max_drive}) &&
       $signed(result.tail_drive) >= -$signed({1'b0, gains.max_drive})))
    else $error("drive outside saturation limit");

  // A disabled sample leaving the product stage gives all-zero drives.
  assert property (@(posedge clk) disable iff (rst)
    (advance && v2 && !ps.enabled) |=>
      (result.fore_drive == '0 && result.aft_drive == '0 && result.tail_drive == '0))
    else $error("disabled sample produced a nonzero drive");

  // A stalled output freezes the error and product stages and their valid flags.
  assert property (@(posedge clk) disable iff (rst)
    (!advance) |=> ($stable(v1) && $stable(v2) && $stable(es) && $stable(ps)))
    else $error("pipeline moved during output stall");

  // Reset empties every stage.
  assert property (@(posedge clk)
    $past(rst) |-> (!v1 && !v2 && !v3))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
